@@ rtl/magic_length_frame_deframer_macros.svh @@
// Assertion macros used by the deframer top-level module.
`ifndef MAGIC_LENGTH_FRAME_DEFRAMER_MACROS_SVH
`define MAGIC_LENGTH_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MLFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, checked outside reset.
`define MLFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

@@ rtl/mlfd_pkg.sv @@
package mlfd_pkg;

  localparam logic [7:0]  MagicFirst      = 8'h94;
  localparam logic [7:0]  MagicSecond     = 8'hC3;
  localparam logic [15:0] MaxPayloadReset = 16'd296;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_MAGIC2  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_OVERSIZE = 2'd2
  } kind_e;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data_byte;
    logic       last;
  } res_t;

endpackage

@@ rtl/mlfd_byte_if.sv @@
interface mlfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/mlfd_res_if.sv @@
interface mlfd_res_if;
  import mlfd_pkg::*;

  logic       valid;
  logic       ready;
  kind_e      kind;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output kind, output data_byte, output last, input ready);
  modport sink (input valid, input kind, input data_byte, input last, output ready);
endinterface

@@ rtl/magic_length_frame_deframer.sv @@
// Frame deframer for a serial byte stream framed as 0x94 0xC3, a big-endian
// 16-bit length and then that many payload bytes.
// Bytes enter on byte_i, one request per byte; results leave on res_o with a
// kind, a data byte and a last flag. Header bytes and a wrong second magic byte
// give no result. A zero length gives one empty-frame result, and a length
// above max_payload gives one oversize result; both carry last and data zero.
// max_payload is written through cfg_we_i and cfg_data_i, and resets to 296.
// The user must write it only while the block is idle; the block does not enforce it.
// A byte is taken into an input register, parsed by the phase machine and, if it
// yields a result, lands in the output register. One byte can be accepted every
// cycle, limited only by the single output register.
// When the receiver stalls, the output register holds its result and bytes
// that yield no result keep flowing; once a byte that yields a result waits in
// the input register, byte_i.ready falls until the output is taken.
// Reset returns the parser to hunting for the first magic byte, empties both
// registers and restores max_payload to 296.
module magic_length_frame_deframer (
  input  logic               clk_i,
  input  logic               rst_ni,
  mlfd_byte_if.sink          byte_i,
  mlfd_res_if.source         res_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_data_i
);
  import mlfd_pkg::*;
  `include "magic_length_frame_deframer_macros.svh"

  logic [15:0] max_payload_q;
  logic        in_full_q, in_full_d;
  logic [7:0]  in_byte_q;
  logic        out_valid_q, out_valid_d;
  res_t        out_res_q;
  res_t        res;
  logic        out_free;
  logic        advance;
  logic        in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
    end else if (cfg_we_i) begin
      max_payload_q <= cfg_data_i;
    end
  end

  mlfd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .byte_i        (in_byte_q),
    .max_payload_i (max_payload_q),
    .res_o         (res)
  );

  // A byte that gives no result may move on even while the output is stalled.
  assign out_free     = !out_valid_q || res_o.ready;
  assign advance      = in_full_q && (!res.valid || out_free);
  assign byte_i.ready = !in_full_q || advance;
  assign in_take      = byte_i.valid && byte_i.ready;

  always_comb begin
    in_full_d = in_full_q;
    if (in_take) begin
      in_full_d = 1'b1;
    end else if (advance) begin
      in_full_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && res.valid) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_full_q   <= in_full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= byte_i.rx_byte;
    end
    if (advance && res.valid) begin
      out_res_q <= res;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.kind      = out_res_q.kind;
  assign res_o.data_byte = out_res_q.data_byte;
  assign res_o.last      = out_res_q.last;

  `MLFD_ASSERT_IMP(a_ctrl_result_shape, clk_i, rst_ni, out_valid_q && (out_res_q.kind != KIND_DATA), (out_res_q.data_byte == 8'd0) && out_res_q.last)
  `MLFD_ASSERT_NXT(a_result_loaded, clk_i, rst_ni, advance && res.valid, out_valid_q)
  `MLFD_ASSERT_NXT(a_held_byte_kept, clk_i, rst_ni, in_full_q && !advance, in_full_q && $stable(in_byte_q))
  `MLFD_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, advance && res.valid, out_free)

endmodule

@@ rtl/mlfd_parser.sv @@
module mlfd_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        byte_i,
  input  logic [15:0]       max_payload_i,
  output mlfd_pkg::res_t    res_o
);
  import mlfd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] count_q, count_d;
  logic [15:0] len_full;
  logic [15:0] count_inc;

  assign len_full  = {len_q[15:8], byte_i};
  assign count_inc = count_q + 16'd1;

  always_comb begin
    phase_d         = phase_q;
    len_d           = len_q;
    count_d         = count_q;
    res_o.valid     = 1'b0;
    res_o.kind      = KIND_DATA;
    res_o.data_byte = 8'd0;
    res_o.last      = 1'b0;
    case (phase_q)
      PH_MAGIC2: begin
        // A wrong second byte is not reconsidered as a first magic byte.
        phase_d = (byte_i == MagicSecond) ? PH_LEN_HI : PH_HUNT;
      end
      PH_LEN_HI: begin
        len_d   = {byte_i, 8'd0};
        phase_d = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_d   = len_full;
        count_d = 16'd0;
        if (len_full > max_payload_i) begin
          phase_d     = PH_HUNT;
          res_o.valid = 1'b1;
          res_o.kind  = KIND_OVERSIZE;
          res_o.last  = 1'b1;
        end else if (len_full == 16'd0) begin
          phase_d     = PH_HUNT;
          res_o.valid = 1'b1;
          res_o.kind  = KIND_EMPTY;
          res_o.last  = 1'b1;
        end else begin
          phase_d = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        count_d         = count_inc;
        res_o.valid     = 1'b1;
        res_o.data_byte = byte_i;
        res_o.last      = (count_inc >= len_q);
        if (count_inc >= len_q) begin
          phase_d = PH_HUNT;
        end
      end
      default: begin
        phase_d = (byte_i == MagicFirst) ? PH_MAGIC2 : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      len_q   <= 16'd0;
      count_q <= 16'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      count_q <= count_d;
    end
  end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mlfd_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int HoldCycles = 60;
  localparam int DrainCycles = 4;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    logic       last;
  } frame_result_t;

  // Tracks the parser state alongside the block and queues the results that
  // each accepted byte should produce.
  class deframer_scoreboard;
    logic [15:0]   max_len;
    phase_e        phase;
    logic [15:0]   frame_len;
    logic [15:0]   rx_count;
    frame_result_t expected_q[$];
    int            errors;
    int            bytes_seen;
    int            kind_seen[3];

    function new();
      max_len    = MaxPayloadReset;
      phase      = PH_HUNT;
      frame_len  = '0;
      rx_count   = '0;
      errors     = 0;
      bytes_seen = 0;
      kind_seen  = '{0, 0, 0};
    endfunction

    function void note_byte(input logic [7:0] value);
      bytes_seen++;
      case (phase)
        PH_MAGIC2: begin
          phase = (value == MagicSecond) ? PH_LEN_HI : PH_HUNT;
        end
        PH_LEN_HI: begin
          frame_len = {value, 8'h00};
          phase     = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          frame_len[7:0] = value;
          rx_count       = '0;
          if (frame_len > max_len) begin
            phase = PH_HUNT;
            expected_q.push_back(frame_result_t'{KIND_OVERSIZE, 8'h00, 1'b1});
          end else if (frame_len == 16'd0) begin
            phase = PH_HUNT;
            expected_q.push_back(frame_result_t'{KIND_EMPTY, 8'h00, 1'b1});
          end else begin
            phase = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          rx_count = rx_count + 16'd1;
          if (rx_count >= frame_len) begin
            phase = PH_HUNT;
            expected_q.push_back(frame_result_t'{KIND_DATA, value, 1'b1});
          end else begin
            expected_q.push_back(frame_result_t'{KIND_DATA, value, 1'b0});
          end
        end
        default: begin
          phase = (value == MagicFirst) ? PH_MAGIC2 : PH_HUNT;
        end
      endcase
    endfunction

    task report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(input kind_e kind, input logic [7:0] data, input logic last);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d data %02h last %0b",
                                  kind, data, last));
        return;
      end
      want = expected_q.pop_front();
      if (kind !== want.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
      if (data !== want.data_byte)
        report_mismatch($sformatf("data_byte %02h, expected %02h", data, want.data_byte));
      if (last !== want.last)
        report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
      kind_seen[int'(want.kind)]++;
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_data;
  bit          calm;
  int          hold_req;
  int          hold_done;
  int          cycles;

  deframer_scoreboard sb = new();

  mlfd_byte_if byte_bus ();
  mlfd_res_if  res_bus ();

  magic_length_frame_deframer u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .byte_i     (byte_bus),
    .res_o      (res_bus),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[magic_length_frame_deframer] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready)
      sb.check_result(res_bus.kind, res_bus.data_byte, res_bus.last);
  end

  // Result side: random back-pressure, plus a long hold-off whenever one is
  // requested, so that both internal registers fill and the input stalls.
  initial begin : result_sink
    int n;
    res_bus.ready = 1'b0;
    hold_done = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        res_bus.ready <= 1'b0;
        for (n = 0; n < HoldCycles; n++) @(negedge clk);
        hold_done++;
      end
      res_bus.ready <= calm ? 1'b1 : ($urandom_range(99) >= 14);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] value);
    while (!calm && $urandom_range(99) < 14) begin
      byte_bus.valid <= 1'b0;
      @(negedge clk);
    end
    byte_bus.valid   <= 1'b1;
    byte_bus.rx_byte <= value;
    do @(posedge clk); while (!byte_bus.ready);
    sb.note_byte(value);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [15:0] len);
    int         i;
    logic [7:0] value;
    send_byte(MagicFirst);
    send_byte(MagicSecond);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    if (len != 16'd0 && len <= sb.max_len) begin
      for (i = 0; i < len; i++) begin
        // Magic bytes inside a payload must pass through untouched.
        if ($urandom_range(99) < 10)
          value = $urandom_range(1) ? MagicFirst : MagicSecond;
        else
          value = 8'($urandom);
        send_byte(value);
      end
    end
  endtask

  // Keeps accepted lengths short so that large limits do not slow the run.
  function automatic logic [15:0] tame_length(input logic [15:0] len,
                                              input logic [15:0] limit);
    if (len <= limit && len > 16'd600)
      return (limit != 16'hFFFF) ? limit + 16'd1 : 16'($urandom_range(1, 12));
    return len;
  endfunction

  function automatic logic [15:0] pick_length(input logic [15:0] limit);
    int r;
    r = $urandom_range(99);
    if (r < 20) return 16'd0;
    if (r < 70) return 16'($urandom_range(1, 12));
    if (r < 85) begin
      r = $urandom_range(2);
      if (r == 0 && limit != 16'd0) return tame_length(limit - 16'd1, limit);
      if (r == 2 && limit != 16'hFFFF) return limit + 16'd1;
      return tame_length(limit, limit);
    end
    return tame_length(16'($urandom), limit);
  endfunction

  task automatic run_random(input int count);
    int         seg_end;
    int         r;
    int         n;
    logic [7:0] value;
    seg_end = sb.bytes_seen + count;
    while (sb.bytes_seen < seg_end) begin
      r = $urandom_range(99);
      if (r < 75) begin
        send_frame(pick_length(sb.max_len));
      end else if (r < 88) begin
        // Line noise; a first magic byte here would throw the framing out.
        for (n = $urandom_range(1, 4); n > 0; n--) begin
          value = 8'($urandom);
          if (value == MagicFirst) value = ~value;
          send_byte(value);
        end
      end else begin
        send_byte(MagicFirst);
        do value = 8'($urandom); while (value == MagicSecond);
        send_byte(value);
      end
    end
  endtask

  task automatic drain();
    byte_bus.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_max(input logic [15:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.max_len = value;
  endtask

  initial begin : stimulus
    logic [15:0] plan [6];
    logic [7:0]  directed [$];
    int          i;
    byte_bus.valid   = 1'b0;
    byte_bus.rx_byte = 8'h00;
    cfg_we           = 1'b0;
    cfg_data         = 16'h0000;
    rst_n            = 1'b0;
    calm             = 1'b0;
    hold_req         = 0;
    plan = '{16'd0, 16'hFFFF, 16'd5, 16'($urandom_range(40)), 16'($urandom),
             MaxPayloadReset};

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty frame, wrong second magic byte, a repeated first magic byte that
    // must not restart the header, a one-byte frame, lengths just above the
    // limit and at the top of the range, and magic bytes carried as payload.
    directed = '{MagicFirst, MagicSecond, 8'h00, 8'h00,
                 MagicFirst, 8'h00,
                 MagicFirst, MagicFirst, MagicSecond,
                 MagicFirst, MagicSecond, 8'h00, 8'h01, 8'h5A,
                 MagicFirst, MagicSecond, 8'h01, 8'h29,
                 MagicFirst, MagicSecond, 8'hFF, 8'hFF,
                 MagicFirst, MagicSecond, 8'h00, 8'h03, MagicFirst, MagicSecond, 8'hFF};
    foreach (directed[k]) send_byte(directed[k]);

    hold_req++;
    send_frame(16'd40);
    run_random(90);

    for (i = 0; i < 6; i++) begin
      drain();
      write_max(plan[i]);
      calm = (i == 1);
      if (plan[i] == 16'hFFFF) send_frame(16'd140);
      else begin
        if (plan[i] <= 16'd600) send_frame(plan[i]);
        send_frame(plan[i] + 16'd1);
      end
      run_random(55);
    end
    calm = 1'b0;
    drain();

    $display("sent %0d bytes; checked %0d payload bytes, %0d empty and %0d oversize frames",
             sb.bytes_seen, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2]);
    $display("max_payload went through 296, 0, 65535, 5 and two random limits");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[magic_length_frame_deframer] OK");
    end else begin
      $display("[magic_length_frame_deframer] ERROR");
    end
    $finish;
  end

endmodule
